[rtl/sssp_pkg.sv]
// Shared widths, opcodes and controller/datapath handshake structs.
package sssp_pkg;

	localparam int VERT_W   = 6;
	localparam int VCNT_W   = 7;
	localparam int WEIGHT_W = 32;
	localparam int COST_W   = 38;
	localparam int EDGE_W   = 2 * VERT_W + WEIGHT_W;

	localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef struct packed {
		logic accept;
		logic init_src;
		logic scan_init;
		logic scan_rd;
		logic settle;
		logic edge_eval;
		logic relax;
		logic out_init;
		logic out_rd;
		logic out_load;
		logic out_next;
	} cmd_t;

	typedef struct packed {
		logic run_fire;
		logic src_ok;
		logic scan_last;
		logic found;
		logic edge_none;
		logic edge_last;
		logic out_fire;
		logic out_last;
	} stat_t;

endpackage

[rtl/sssp_in_if.sv]
// Input channel: edge loads and run requests.
interface sssp_in_if import sssp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [VERT_W-1:0]   vertex_a;
	logic [VERT_W-1:0]   vertex_b;
	logic [WEIGHT_W-1:0] edge_weight;

	modport source (output valid, opcode, vertex_a, vertex_b, edge_weight, input ready);
	modport sink   (input valid, opcode, vertex_a, vertex_b, edge_weight, output ready);
endinterface

[rtl/sssp_out_if.sv]
// Output channel: one path cost result per vertex.
interface sssp_out_if import sssp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VERT_W-1:0] vertex_index;
	logic [COST_W-1:0] path_cost;
	logic              reachable;
	logic              last;

	modport source (output valid, vertex_index, path_cost, reachable, last, input ready);
	modport sink   (input valid, vertex_index, path_cost, reachable, last, output ready);
endinterface

[rtl/sssp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sssp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/sssp_datapath.sv]
// Datapath: edge store, cost memory, vertex marks, min scan and relaxation.
module sssp_datapath import sssp_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [VCNT_W-1:0] cfg_wr_data,
	sssp_in_if.sink           in_ch,
	sssp_out_if.source        out_ch,
	input  cmd_t              cmd,
	output stat_t             stat
);

	localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW  = $clog2(MAX_EDGES + 1);

	logic [VCNT_W-1:0]       vcnt_q, n_q, n_eff;
	logic [VERT_W-1:0]       src_q;
	logic [EW-1:0]           edge_cnt_q;
	logic [MAX_VERTICES-1:0] known_q, settled_q;
	logic                    in_fire, edge_we;

	logic [AW-1:0]     scan_idx_q, sidx_s1, best_idx_q, u_q, o_idx_q;
	logic              sv_s1, found_q;
	logic [COST_W-1:0] best_cost_q, base_q, cand_q;
	logic [EAW-1:0]    e_idx_q;
	logic [VERT_W-1:0] tgt_q;
	logic              hit_q;

	logic [EDGE_W-1:0] edge_rdata;
	logic [COST_W-1:0] cost_rdata, cost_wdata;
	logic [AW-1:0]     cost_raddr, cost_waddr;
	logic              cost_we;

	logic [VERT_W-1:0]   ea, eb, tgt;
	logic [WEIGHT_W-1:0] ew;
	logic                a_is_u, b_is_u, in_range, hit;

	logic              out_vld_q, out_reach_q, out_last_q;
	logic [VERT_W-1:0] out_idx_q;
	logic [COST_W-1:0] out_cost_q;

	// clamp the configured vertex count to 1..MAX_VERTICES
	always_comb begin
		if (vcnt_q == '0) begin
			n_eff = VCNT_W'(1);
		end else if (vcnt_q > VCNT_W'(MAX_VERTICES)) begin
			n_eff = VCNT_W'(MAX_VERTICES);
		end else begin
			n_eff = vcnt_q;
		end
	end

	assign in_ch.ready = cmd.accept;
	assign in_fire     = in_ch.valid & cmd.accept;
	assign edge_we     = in_fire & (in_ch.opcode == OP_EDGE) &
	                     (edge_cnt_q != EW'(MAX_EDGES));

	// edge endpoints and relaxation target
	assign ea       = edge_rdata[EDGE_W-1 -: VERT_W];
	assign eb       = edge_rdata[WEIGHT_W +: VERT_W];
	assign ew       = edge_rdata[WEIGHT_W-1:0];
	assign a_is_u   = (ea == VERT_W'(u_q));
	assign b_is_u   = (eb == VERT_W'(u_q));
	assign in_range = (VCNT_W'(ea) < n_q) && (VCNT_W'(eb) < n_q);
	assign tgt      = a_is_u ? eb : ea;
	assign hit      = in_range & (a_is_u | b_is_u) & ~settled_q[tgt[AW-1:0]];

	// cost memory port select
	always_comb begin
		if (cmd.edge_eval) begin
			cost_raddr = tgt[AW-1:0];
		end else if (cmd.out_rd) begin
			cost_raddr = o_idx_q;
		end else begin
			cost_raddr = scan_idx_q;
		end
		cost_waddr = cmd.init_src ? src_q[AW-1:0] : tgt_q[AW-1:0];
		cost_wdata = cmd.init_src ? '0 : cand_q;
		cost_we    = cmd.init_src |
		             (cmd.relax & hit_q &
		              (~known_q[tgt_q[AW-1:0]] | (cand_q < cost_rdata)));
	end

	sssp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_cnt_q[EAW-1:0]),
		.wdata ({in_ch.vertex_a, in_ch.vertex_b, in_ch.edge_weight}),
		.raddr (e_idx_q),
		.rdata (edge_rdata)
	);

	sssp_ram #(.WIDTH(COST_W), .DEPTH(MAX_VERTICES)) u_cost_ram (
		.clk   (clk),
		.we    (cost_we),
		.waddr (cost_waddr),
		.wdata (cost_wdata),
		.raddr (cost_raddr),
		.rdata (cost_rdata)
	);

	// control registers: config, edge count, marks, scan and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q     <= VCNT_RESET;
			edge_cnt_q <= '0;
			known_q    <= '0;
			settled_q  <= '0;
			sv_s1      <= 1'b0;
			found_q    <= 1'b0;
			hit_q      <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcnt_q <= cfg_wr_data;
			end
			if (edge_we) begin
				edge_cnt_q <= edge_cnt_q + EW'(1);
			end
			if (stat.run_fire) begin
				known_q   <= '0;
				settled_q <= '0;
			end
			if (cmd.init_src) begin
				known_q[src_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.settle) begin
				settled_q[best_idx_q] <= 1'b1;
			end
			if (cost_we && cmd.relax) begin
				known_q[tgt_q[AW-1:0]] <= 1'b1;
			end
			sv_s1 <= cmd.scan_rd;
			if (cmd.scan_init) begin
				found_q <= 1'b0;
			end else if (sv_s1 && known_q[sidx_s1] && !settled_q[sidx_s1] &&
			             (!found_q || cost_rdata < best_cost_q)) begin
				found_q <= 1'b1;
			end
			if (cmd.edge_eval) begin
				hit_q <= hit;
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (stat.run_fire) begin
			src_q <= in_ch.vertex_a;
			n_q   <= n_eff;
		end
		if (cmd.scan_init) begin
			scan_idx_q <= '0;
		end else if (cmd.scan_rd) begin
			scan_idx_q <= scan_idx_q + AW'(1);
		end
		sidx_s1 <= scan_idx_q;
		if (!cmd.scan_init && sv_s1 && known_q[sidx_s1] && !settled_q[sidx_s1] &&
		    (!found_q || cost_rdata < best_cost_q)) begin
			best_idx_q  <= sidx_s1;
			best_cost_q <= cost_rdata;
		end
		if (cmd.settle) begin
			base_q  <= best_cost_q;
			u_q     <= best_idx_q;
			e_idx_q <= '0;
		end else if (cmd.relax) begin
			e_idx_q <= e_idx_q + EAW'(1);
		end
		if (cmd.edge_eval) begin
			cand_q <= base_q + COST_W'(ew);
			tgt_q  <= tgt;
		end
		if (cmd.out_init) begin
			o_idx_q <= '0;
		end else if (cmd.out_next) begin
			o_idx_q <= o_idx_q + AW'(1);
		end
		if (cmd.out_load) begin
			out_idx_q   <= VERT_W'(o_idx_q);
			out_reach_q <= known_q[o_idx_q];
			out_cost_q  <= known_q[o_idx_q] ? cost_rdata : '0;
			out_last_q  <= (VCNT_W'(o_idx_q) == n_q - VCNT_W'(1));
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.vertex_index = out_idx_q;
	assign out_ch.path_cost    = out_cost_q;
	assign out_ch.reachable    = out_reach_q;
	assign out_ch.last         = out_last_q;

	// status toward the controller
	assign stat.run_fire  = in_fire & (in_ch.opcode == OP_RUN);
	assign stat.src_ok    = (VCNT_W'(src_q) < n_q);
	assign stat.scan_last = (VCNT_W'(scan_idx_q) == n_q - VCNT_W'(1));
	assign stat.found     = found_q;
	assign stat.edge_none = (edge_cnt_q == '0);
	assign stat.edge_last = (EW'(e_idx_q) == edge_cnt_q - EW'(1));
	assign stat.out_fire  = out_vld_q & out_ch.ready;
	assign stat.out_last  = out_last_q;

endmodule

[rtl/sssp_ctrl.sv]
// Controller: sequences init, min scan, edge relaxation and result output.
module sssp_ctrl import sssp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN, S_TAIL, S_PICK, S_EDGE_RD, S_EDGE_EVAL,
		S_RELAX, S_OUT_RD, S_OUT_LOAD, S_OUT_WAIT
	} state_t;

	state_t state_q, state_d;

	// decode commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = 1'b1;
				if (stat.run_fire) state_d = S_INIT;
			end
			S_INIT: begin
				if (stat.src_ok) begin
					cmd.init_src  = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					cmd.out_init = 1'b1;
					state_d      = S_OUT_RD;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) state_d = S_TAIL;
			end
			S_TAIL: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				if (stat.found) begin
					cmd.settle = 1'b1;
					if (stat.edge_none) begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end else begin
						state_d = S_EDGE_RD;
					end
				end else begin
					cmd.out_init = 1'b1;
					state_d      = S_OUT_RD;
				end
			end
			S_EDGE_RD: begin
				state_d = S_EDGE_EVAL;
			end
			S_EDGE_EVAL: begin
				cmd.edge_eval = 1'b1;
				state_d       = S_RELAX;
			end
			S_RELAX: begin
				cmd.relax = 1'b1;
				if (stat.edge_last) begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					state_d = S_EDGE_RD;
				end
			end
			S_OUT_RD: begin
				cmd.out_rd = 1'b1;
				state_d    = S_OUT_LOAD;
			end
			S_OUT_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_OUT_WAIT;
			end
			S_OUT_WAIT: begin
				if (stat.out_fire) begin
					if (stat.out_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = S_OUT_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/single_source_shortest_paths.sv]
// Edge load: one transfer per cycle while idle. Run: per settled vertex, a min scan over
// the n vertices, then a read, evaluate and relax step per stored edge (cost memory
// read-modify-write), then each result is read, loaded and held until taken; the block
// takes no input until the last result. Throughput is one run at a time; ready is high
// only between runs. Reset clears control state, sets vertex_count to 64 and empties
// the edge store; no memory clearing pass is needed.
module single_source_shortest_paths import sssp_pkg::*; #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [VCNT_W-1:0] cfg_wr_data,
	sssp_in_if.sink           in_ch,
	sssp_out_if.source        out_ch
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	sssp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// storage and arithmetic
	sssp_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule
